@@ rtl/core/ncf_pkg.sv @@
// ----------------------------------------------------------------------------
// ncf_pkg: shared types and constants of the nixie multiplex crossfade driver
// Holds the channel payload structs, the operation and register codes, the
// controller states and the command/status bundles between the two halves.
// ----------------------------------------------------------------------------
`default_nettype none

package ncf_pkg;

	localparam int unsigned CFG_IDX_W  = 3;
	localparam int unsigned CFG_DATA_W = 16;

	// Register indexes of the configuration port.
	localparam logic [CFG_IDX_W-1:0] REG_DOT_MODE      = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_BLINK_MODE    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_FADE_LENGTH   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_FADE_STEP     = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_QUARTER_ONE   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_QUARTER_TWO   = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_QUARTER_THREE = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_DIM_LEVEL     = 3'd7;

	// Operation codes carried by an input beat.
	typedef enum logic [1:0] {
		OP_TICK  = 2'd0,
		OP_FADE  = 2'd1,
		OP_CLEAR = 2'd2
	} op_t;

	// Dot, blink and dim mode codes.
	localparam logic [1:0] DOT_ON    = 2'd1;
	localparam logic [1:0] DOT_FLASH = 2'd2;
	localparam logic [1:0] BLINK_HOURS   = 2'd1;
	localparam logic [1:0] BLINK_MINUTES = 2'd2;
	localparam logic [1:0] BLINK_WHOLE   = 2'd3;
	localparam logic [1:0] DIM_DARK    = 2'd1;
	localparam logic [1:0] DIM_DARKEST = 2'd2;

	localparam logic [3:0] BLANK_CODE = 4'hf;
	localparam logic [3:0] EARLY_CUT_CODE = 4'ha;

	typedef struct packed {
		logic [1:0]  operation;
		logic [15:0] bcd_value;
	} in_item_t;

	typedef struct packed {
		logic [3:0]  cathode_code;
		logic [3:0]  anode_enable;
		logic        dot_on;
		logic        repeat_pulse;
		logic        wake_pulse;
		logic [15:0] settled_value;
	} out_item_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EXEC,
		ST_DIV,
		ST_SLOW,
		ST_EMIT
	} state_t;

	// Controller to datapath.
	typedef struct packed {
		logic load;       // capture the accepted beat
		logic exec;       // per-beat update, fade setup and countdown
		logic div_start;  // start the remainder of the countdown by the step
		logic slow;       // finish the slow tick: duty, codes, anode select
		logic emit;       // copy the result into the output register
	} ctrl_cmd_t;

	// Datapath to controller.
	typedef struct packed {
		logic slow_tick;  // the beat in work is a tick that lands on a slow tick
		logic div_busy;   // remainder unit still iterating
	} dp_stat_t;

endpackage : ncf_pkg

`default_nettype wire

@@ rtl/core/ncf_if.sv @@
// ----------------------------------------------------------------------------
// ncf_if: valid/ready channels of the nixie multiplex crossfade driver
// One interface for the input beats and one for the result beats.
// ----------------------------------------------------------------------------
`default_nettype none

interface ncf_in_if;
	logic             valid;
	logic             ready;
	ncf_pkg::in_item_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface : ncf_in_if

interface ncf_out_if;
	logic              valid;
	logic              ready;
	ncf_pkg::out_item_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface : ncf_out_if

`default_nettype wire

@@ rtl/core/ncf_rem.sv @@
// ----------------------------------------------------------------------------
// ncf_rem: iterative remainder unit
// Restoring remainder of a 16-bit dividend by a 16-bit divisor, one bit per
// cycle. A zero divisor is taken as one.
// ----------------------------------------------------------------------------
`default_nettype none

module ncf_rem (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	input  wire logic [15:0] dividend,
	input  wire logic [15:0] divisor,
	output logic             busy,
	output logic             rem_zero
);

	logic [15:0] num_q;
	logic [15:0] den_q;
	logic [15:0] rem_q;
	logic [4:0]  cnt_q;
	logic [16:0] trial;
	logic [16:0] diff;

	assign trial = {rem_q, num_q[15]};
	assign diff  = trial - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= 5'd16;
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - 5'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= dividend;
			den_q <= (divisor == '0) ? 16'd1 : divisor;
			rem_q <= '0;
		end else if (cnt_q != '0) begin
			num_q <= {num_q[14:0], 1'b0};
			rem_q <= diff[16] ? trial[15:0] : diff[15:0];
		end
	end

	assign busy     = (cnt_q != '0);
	assign rem_zero = (rem_q == '0);

endmodule : ncf_rem

`default_nettype wire

@@ rtl/core/ncf_dp.sv @@
// ----------------------------------------------------------------------------
// ncf_dp: datapath of the nixie multiplex crossfade driver
// Holds the configuration registers, the display state, the remainder unit
// and the result register, and updates them on the controller's commands.
// ----------------------------------------------------------------------------
`default_nettype none

module ncf_dp (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            cfg_we,
	input  wire logic [ncf_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [ncf_pkg::CFG_DATA_W-1:0] cfg_data,
	input  wire ncf_pkg::in_item_t               in_data,
	input  wire ncf_pkg::ctrl_cmd_t              ctl,
	output ncf_pkg::dp_stat_t                    stat,
	output ncf_pkg::out_item_t                   out_data
);

	// Configuration.
	logic [1:0]  dot_mode_q;
	logic [2:0]  blink_mode_q;
	logic [15:0] fade_length_q;
	logic [15:0] fade_step_q;
	logic [15:0] quarter_one_q;
	logic [15:0] quarter_two_q;
	logic [15:0] quarter_three_q;
	logic [1:0]  dim_level_q;

	// Captured beat.
	logic [1:0]  op_q;
	logic [15:0] bcd_q;

	// Display state.
	logic [7:0]  phase_q;
	logic [15:0] blink_q;
	logic [1:0]  digit_q;
	logic [15:0] target_q;
	logic [15:0] shown_q;
	logic [15:0] from_q;
	logic [15:0] to_q;
	logic        pending_q;
	logic [15:0] remain_q;
	logic [2:0]  duty_q;
	logic [4:0]  fphase_q;
	logic        fade_act_q;
	logic [3:0]  cath_q;
	logic [3:0]  anode_q;
	logic        dot_q;
	logic        rep_q;
	logic        wake_q;

	// Per-beat logic.
	logic [7:0]  phase_nx;
	logic [4:0]  low5;
	logic        slow_tick;
	logic        duty_one;
	logic        dot_nx;
	logic        wake_nx;
	logic [15:0] blink_inc;
	logic [15:0] blink_nx;
	logic        rep_nx;
	logic        cut_nx;
	logic [15:0] fr_eff;
	logic [2:0]  duty_eff;
	logic [4:0]  fphase_eff;
	logic [15:0] fr_dec;

	// Slow tick finish.
	logic        rem_zero;
	logic        div_busy;
	logic        fade_done;
	logic [2:0]  duty_c;
	logic [4:0]  fphase_c;
	logic [15:0] from_c;
	logic [15:0] disp;
	logic [15:0] masked;
	logic [3:0]  cath_nx;

	function automatic logic [3:0] swap_nibble(input logic [3:0] x);
		return {x[0], x[3], x[1], x[2]};
	endfunction

	function automatic logic [15:0] bcd_to_codes(input logic [15:0] v);
		return {swap_nibble(v[15:12]), swap_nibble(v[11:8]),
			swap_nibble(v[7:4]), swap_nibble(v[3:0])};
	endfunction

	always_comb begin
		phase_nx  = phase_q + 8'd1;
		low5      = phase_nx[4:0];
		slow_tick = (op_q == ncf_pkg::OP_TICK) && (low5 == '0);
		duty_one  = (dot_mode_q == ncf_pkg::DOT_ON) ||
			((dot_mode_q != '0) && (blink_q <= quarter_two_q));
		dot_nx    = ((phase_nx[2:0] == '0) && duty_one) ||
			((dot_mode_q == ncf_pkg::DOT_FLASH) &&
			 ((blink_q <= 16'd4) || (phase_nx[6:0] == '0)));
		wake_nx   = (phase_nx[5:0] == '0);
		blink_inc = blink_q + 16'd1;
		blink_nx  = ({1'b0, blink_inc} > {quarter_two_q, 1'b0}) ? 16'd0 : blink_inc;
		rep_nx    = (blink_mode_q != '0) &&
			((blink_nx == quarter_one_q) || (blink_nx == quarter_two_q) ||
			 (blink_nx == quarter_three_q) || (blink_nx == 16'd1));
		cut_nx    = ((low5 == 5'h18) && (cath_q == ncf_pkg::EARLY_CUT_CODE)) ||
			((dim_level_q == ncf_pkg::DIM_DARKEST) && (low5 == 5'h08)) ||
			((dim_level_q == ncf_pkg::DIM_DARK) && (low5 == 5'h10));

		// A pending fade start replaces the countdown first.
		fr_eff     = remain_q;
		duty_eff   = duty_q;
		fphase_eff = fphase_q;
		if (pending_q) begin
			if (fade_length_q == '0) begin
				fr_eff   = 16'd1;
				duty_eff = 3'd1;
			end else begin
				fr_eff     = fade_length_q;
				duty_eff   = 3'd4;
				fphase_eff = '0;
			end
		end
		fr_dec = (fr_eff != '0) ? (fr_eff - 16'd1) : 16'd0;

		duty_c    = duty_q;
		fphase_c  = fphase_q;
		from_c    = from_q;
		fade_done = 1'b0;
		if (fade_act_q) begin
			if (rem_zero && (duty_q != '0)) begin
				duty_c = duty_q - 3'd1;
			end
			if (remain_q == '0) begin
				fade_done = 1'b1;
				fphase_c  = '0;
				from_c    = to_q;
			end
		end
		disp = ({1'b0, fphase_c[4:3]} < duty_c) ? from_c : to_q;

		masked = disp;
		if ((blink_mode_q != '0) && !blink_mode_q[2] && (blink_q > quarter_two_q)) begin
			unique case (blink_mode_q[1:0])
				ncf_pkg::BLINK_HOURS:   masked = disp | 16'hff00;
				ncf_pkg::BLINK_MINUTES: masked = disp | 16'h00ff;
				ncf_pkg::BLINK_WHOLE:   masked = 16'hffff;
				default:                masked = disp;
			endcase
		end
		cath_nx = masked[{digit_q, 2'b00} +: 4];
	end

	ncf_rem u_rem (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (ctl.div_start),
		.dividend (fr_dec),
		.divisor  (fade_step_q),
		.busy     (div_busy),
		.rem_zero (rem_zero)
	);

	assign stat.slow_tick = slow_tick;
	assign stat.div_busy  = div_busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dot_mode_q      <= '0;
			blink_mode_q    <= '0;
			fade_length_q   <= '0;
			fade_step_q     <= 16'd1;
			quarter_one_q   <= 16'hffff;
			quarter_two_q   <= 16'hffff;
			quarter_three_q <= 16'hffff;
			dim_level_q     <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				ncf_pkg::REG_DOT_MODE:      dot_mode_q      <= cfg_data[1:0];
				ncf_pkg::REG_BLINK_MODE:    blink_mode_q    <= cfg_data[2:0];
				ncf_pkg::REG_FADE_LENGTH:   fade_length_q   <= cfg_data;
				ncf_pkg::REG_FADE_STEP:     fade_step_q     <= cfg_data;
				ncf_pkg::REG_QUARTER_ONE:   quarter_one_q   <= cfg_data;
				ncf_pkg::REG_QUARTER_TWO:   quarter_two_q   <= cfg_data;
				ncf_pkg::REG_QUARTER_THREE: quarter_three_q <= cfg_data;
				ncf_pkg::REG_DIM_LEVEL:     dim_level_q     <= cfg_data[1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			op_q  <= in_data.operation;
			bcd_q <= in_data.bcd_value;
		end
		if (ctl.emit) begin
			out_data.cathode_code  <= cath_q;
			out_data.anode_enable  <= anode_q;
			out_data.dot_on        <= dot_q;
			out_data.repeat_pulse  <= rep_q;
			out_data.wake_pulse    <= wake_q;
			out_data.settled_value <= shown_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= '0;
			blink_q    <= '0;
			digit_q    <= '0;
			target_q   <= '0;
			shown_q    <= '0;
			from_q     <= 16'hffff;
			to_q       <= 16'hffff;
			pending_q  <= 1'b0;
			remain_q   <= '0;
			duty_q     <= '0;
			fphase_q   <= '0;
			fade_act_q <= 1'b0;
			cath_q     <= '0;
			anode_q    <= '0;
			dot_q      <= 1'b0;
			rep_q      <= 1'b0;
			wake_q     <= 1'b0;
		end else begin
			if (ctl.exec) begin
				dot_q  <= 1'b0;
				rep_q  <= 1'b0;
				wake_q <= 1'b0;
				unique case (op_q)
					ncf_pkg::OP_TICK: begin
						phase_q <= phase_nx;
						dot_q   <= dot_nx;
						wake_q  <= wake_nx;
						if (slow_tick) begin
							blink_q    <= blink_nx;
							rep_q      <= rep_nx;
							pending_q  <= 1'b0;
							remain_q   <= fr_dec;
							duty_q     <= duty_eff;
							fphase_q   <= fphase_eff;
							fade_act_q <= (fr_eff != '0);
						end else if (cut_nx) begin
							anode_q <= '0;
						end
					end
					ncf_pkg::OP_FADE: begin
						target_q  <= bcd_q;
						to_q      <= bcd_to_codes(bcd_q);
						pending_q <= 1'b1;
					end
					ncf_pkg::OP_CLEAR: begin
						blink_q <= '0;
					end
					default: ;
				endcase
			end
			if (ctl.slow) begin
				duty_q   <= duty_c;
				fphase_q <= fphase_c + 5'd1;
				from_q   <= from_c;
				if (fade_done) begin
					shown_q <= target_q;
				end
				cath_q  <= cath_nx;
				anode_q <= (cath_nx != ncf_pkg::BLANK_CODE) ? (4'b0001 << digit_q) : 4'b0000;
				digit_q <= digit_q + 2'd1;
			end
		end
	end

endmodule : ncf_dp

`default_nettype wire

@@ rtl/core/ncf_ctrl.sv @@
// ----------------------------------------------------------------------------
// ncf_ctrl: controller of the nixie multiplex crossfade driver
// Sequences one beat through capture, update, remainder wait and slow tick
// finish (slow ticks only) and hand-off, and owns the valid/ready handshakes.
// ----------------------------------------------------------------------------
`default_nettype none

module ncf_ctrl (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	output logic                     in_ready,
	output logic                     out_valid,
	input  wire logic                out_ready,
	input  wire ncf_pkg::dp_stat_t   stat,
	output ncf_pkg::ctrl_cmd_t       ctl
);

	ncf_pkg::state_t state_q;
	ncf_pkg::state_t state_nx;
	logic            out_valid_q;
	logic            slot_free;

	assign slot_free = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ncf_pkg::ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_nx;
			out_valid_q <= ctl.emit || (out_valid_q && !out_ready);
		end
	end

	always_comb begin
		state_nx = state_q;
		ctl      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			ncf_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					ctl.load = 1'b1;
					state_nx = ncf_pkg::ST_EXEC;
				end
			end
			ncf_pkg::ST_EXEC: begin
				ctl.exec = 1'b1;
				if (stat.slow_tick) begin
					ctl.div_start = 1'b1;
					state_nx      = ncf_pkg::ST_DIV;
				end else begin
					state_nx = ncf_pkg::ST_EMIT;
				end
			end
			ncf_pkg::ST_DIV: begin
				if (!stat.div_busy) begin
					state_nx = ncf_pkg::ST_SLOW;
				end
			end
			ncf_pkg::ST_SLOW: begin
				ctl.slow = 1'b1;
				state_nx = ncf_pkg::ST_EMIT;
			end
			ncf_pkg::ST_EMIT: begin
				if (slot_free) begin
					ctl.emit = 1'b1;
					state_nx = ncf_pkg::ST_IDLE;
				end
			end
			default: begin
				state_nx = ncf_pkg::ST_IDLE;
			end
		endcase
	end

	assign out_valid = out_valid_q;

endmodule : ncf_ctrl

`default_nettype wire

@@ rtl/core/nixie_mux_crossfade_driver.sv @@
// ----------------------------------------------------------------------------
// nixie_mux_crossfade_driver: four-digit nixie multiplex driver with crossfade
// Advances the phase and blink counters, drives the neon dot, runs a duty
// crossfade between old and new digit codes and selects the next anode.
// ----------------------------------------------------------------------------
//
//   Channel  Direction  Payload                                   Beat when
//   req      in         operation, bcd_value                      valid & ready
//   rsp      out        cathode_code, anode_enable, dot_on,       valid & ready
//                       repeat_pulse, wake_pulse, settled_value
//   cfg      in         cfg_index, cfg_data                       cfg_we
//
// A slow tick (every 32nd tick) goes through capture, update, remainder wait,
// slow tick finish and emit; the remainder of the fade countdown by the fade
// step runs one bit per cycle. Other beats skip the remainder wait and the
// slow tick finish, and the controller returns to idle before the next beat.
// One beat is in work at a time; the result register lets the next beat be
// accepted while the previous result still waits on rsp.ready. Reset (arst_n
// low) is asynchronous; it clears all but the beat, payload and divider data.
//
`default_nettype none

module nixie_mux_crossfade_driver (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	ncf_in_if.sink                               req,
	ncf_out_if.source                            rsp,
	input  wire logic                            cfg_we,
	input  wire logic [ncf_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [ncf_pkg::CFG_DATA_W-1:0] cfg_data
);

	// The controller and the datapath talk only through these two bundles.
	ncf_pkg::ctrl_cmd_t ctl;
	ncf_pkg::dp_stat_t  stat;

	// The controller owns both handshakes and walks each beat through its
	// states; the datapath never looks at valid or ready.
	ncf_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (req.valid),
		.in_ready  (req.ready),
		.out_valid (rsp.valid),
		.out_ready (rsp.ready),
		.stat      (stat),
		.ctl       (ctl)
	);

	// The datapath holds every register of the display and the result
	// register that drives the rsp payload.
	ncf_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_data   (req.data),
		.ctl       (ctl),
		.stat      (stat),
		.out_data  (rsp.data)
	);

endmodule : nixie_mux_crossfade_driver

`default_nettype wire

@@ rtl/core/ncf_chk.sv @@
// ----------------------------------------------------------------------------
// ncf_chk: port checker of the nixie multiplex crossfade driver
// Watches the handshakes and the anode drive on the top level's ports.
// ----------------------------------------------------------------------------
`default_nettype none

module ncf_chk (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       req_valid,
	input wire logic       req_ready,
	input wire logic       rsp_valid,
	input wire logic       rsp_ready,
	input wire logic [3:0] cathode_code,
	input wire logic [3:0] anode_enable
);

	// At most one anode is driven while a result is valid.
	a_anode_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> $onehot0(anode_enable))
		else $error("more than one anode driven");

	// A blank cathode code never comes with a lit anode in a valid result.
	a_blank_dark: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && (cathode_code == ncf_pkg::BLANK_CODE)) |-> (anode_enable == 4'b0000))
		else $error("anode lit on a blank digit");

	// One beat in work at a time: an accepted beat closes the input.
	a_one_in_work: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && req_ready) |=> !req_ready)
		else $error("input accepted while a beat is in work");

	// A stalled result stays valid and holds its cathode code and anode drive.
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && !rsp_ready) |=>
			(rsp_valid && $stable(cathode_code) && $stable(anode_enable)))
		else $error("result changed while stalled");

endmodule : ncf_chk

bind nixie_mux_crossfade_driver ncf_chk u_ncf_chk (
	.clk          (clk),
	.arst_n       (arst_n),
	.req_valid    (req.valid),
	.req_ready    (req.ready),
	.rsp_valid    (rsp.valid),
	.rsp_ready    (rsp.ready),
	.cathode_code (rsp.data.cathode_code),
	.anode_enable (rsp.data.anode_enable)
);

`default_nettype wire
